### design/lphm_pkg.sv
package lphm_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int TRY_W     = SLOT_BITS + 1;
	localparam int KEY_BYTES = 8;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 5;

	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

	// only the low index bits of the hash reach the slot number, and both xor and a
	// product modulo a power of two depend on the low bits alone
	localparam logic [SLOT_BITS-1:0] HASH_BASIS = FNV_BASIS[SLOT_BITS-1:0];
	localparam logic [SLOT_BITS-1:0] HASH_PRIME = FNV_PRIME[SLOT_BITS-1:0];

	localparam logic REQ_PUT = 1'b0;
	localparam logic REQ_GET = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [SLOT_BITS-1:0] wr_addr;
		entry_t               wr_data;
	} tbl_req_t;

endpackage

### design/linear_probe_hash_map_top.sv
// channel | handshake           | payload
// --------+---------------------+---------------------------------------------
// in      | in_valid / in_ready | req_type, key_bytes, write_value
// out     | out_valid/out_ready | status, read_value, entry_count
//
// after reset a clearing pass writes every slot empty, one slot a cycle; in_ready
// stays low until it ends
// each item probes p slots (1 to SLOTS) before its result is registered; each probe
// is one read of the slot memory
// in_ready rises again the cycle after the result is registered, and a waiting
// result does not hold back the next item; a full output register stalls the final
// decision of the next item until the old result is taken
module linear_probe_hash_map_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [lphm_pkg::KEY_W-1:0]        key_bytes,
	input  logic signed [lphm_pkg::VAL_W-1:0] write_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [lphm_pkg::VAL_W-1:0] read_value,
	output logic [lphm_pkg::CNT_W-1:0]        entry_count
);

	lphm_pkg::state_t state_q, state_d;

	// request held for the whole probe
	logic                          type_q;
	logic [lphm_pkg::KEY_W-1:0]    key_q;
	logic [lphm_pkg::VAL_W-1:0]    wval_q;

	logic [lphm_pkg::SLOT_BITS-1:0] clr_addr_q, clr_addr_d;
	logic [lphm_pkg::SLOT_BITS-1:0] idx_q, idx_d;
	logic [lphm_pkg::TRY_W-1:0]     tries_q, tries_d;
	logic [lphm_pkg::TRY_W-1:0]     occ_q, occ_d;

	// output register
	logic                          out_valid_q;
	logic [1:0]                    status_q, status_d;
	logic [lphm_pkg::VAL_W-1:0]    rval_q, rval_d;
	logic                          out_load;

	logic [lphm_pkg::KEY_W-1:0]     key_norm;
	logic [lphm_pkg::SLOT_BITS-1:0] home_idx;
	lphm_pkg::tbl_req_t             tbl_req;
	lphm_pkg::entry_t               ent;

	logic hit, empty, last_try, probe_done, out_free;

	lphm_hash u_hash (
		.key_raw  (key_q),
		.key_norm (key_norm),
		.home_idx (home_idx)
	);

	lphm_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (ent)
	);

	// slot decision on the entry from the most recent table read
	assign hit        = ent.used && (ent.key == key_norm);
	assign empty      = !ent.used;
	assign last_try   = (tries_q == lphm_pkg::TRY_W'(lphm_pkg::SLOTS));
	assign probe_done = hit || empty || last_try;
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		clr_addr_d = clr_addr_q;
		idx_d      = idx_q;
		tries_d    = tries_q;
		occ_d      = occ_q;
		status_d   = status_q;
		rval_d     = rval_q;
		out_load   = 1'b0;
		in_ready   = 1'b0;
		tbl_req    = '0;
		unique case (state_q)
			lphm_pkg::S_CLEAR: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_addr = clr_addr_q;
				tbl_req.wr_data = '0;
				clr_addr_d      = clr_addr_q + 1'b1;
				if (clr_addr_q == lphm_pkg::SLOT_BITS'(lphm_pkg::SLOTS - 1)) begin
					state_d = lphm_pkg::S_IDLE;
				end
			end
			lphm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lphm_pkg::S_HASH;
				end
			end
			lphm_pkg::S_HASH: begin
				// first read at the home slot
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_addr = home_idx;
				idx_d           = home_idx;
				tries_d         = lphm_pkg::TRY_W'(1);
				state_d         = lphm_pkg::S_CHECK;
			end
			lphm_pkg::S_CHECK: begin
				if (!probe_done) begin
					// walk on to the next slot, wrapping at the end
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_addr = idx_q + 1'b1;
					idx_d           = idx_q + 1'b1;
					tries_d         = tries_q + 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = lphm_pkg::S_IDLE;
					rval_d   = '0;
					if (type_q == lphm_pkg::REQ_PUT) begin
						if (hit || empty) begin
							tbl_req.wr_en         = 1'b1;
							tbl_req.wr_addr       = idx_q;
							tbl_req.wr_data.used  = 1'b1;
							tbl_req.wr_data.key   = key_norm;
							tbl_req.wr_data.value = wval_q;
							status_d              = lphm_pkg::ST_OK;
							if (empty) begin
								occ_d = occ_q + 1'b1;
							end
						end else begin
							status_d = lphm_pkg::ST_FULL;
						end
					end else begin
						if (hit) begin
							status_d = lphm_pkg::ST_OK;
							rval_d   = ent.value;
						end else begin
							status_d = lphm_pkg::ST_NOT_FOUND;
						end
					end
				end
			end
			default: begin
				state_d = lphm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphm_pkg::S_CLEAR;
			clr_addr_q  <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			tries_q     <= '0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
			occ_q      <= occ_d;
			tries_q    <= tries_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			type_q <= req_type;
			key_q  <= key_bytes;
			wval_q <= write_value;
		end
		idx_q    <= idx_d;
		status_q <= status_d;
		rval_q   <= rval_d;
		if (out_load) begin
			entry_count <= lphm_pkg::CNT_W'(occ_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = rval_q;

	// a finished result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded over a waiting result");

	// the count of filled slots stays within the table
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= lphm_pkg::TRY_W'(lphm_pkg::SLOTS))
		else $error("entry count beyond slot count");

	// table full is only reported with every slot taken
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && status_d == lphm_pkg::ST_FULL)
		|-> occ_q == lphm_pkg::TRY_W'(lphm_pkg::SLOTS))
		else $error("table full reported with free slots");

	// the probe never reads past a full lap of the table
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lphm_pkg::S_CHECK) |-> (tries_q != '0 &&
		tries_q <= lphm_pkg::TRY_W'(lphm_pkg::SLOTS)))
		else $error("probe count out of range");

	// no lookup is issued while the table is being cleared
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lphm_pkg::S_CLEAR) |-> !tbl_req.rd_en && !in_ready)
		else $error("access during clearing pass");

endmodule

### design/lphm_hash.sv
// key normalisation and home slot from the fnv-1a hash
module lphm_hash (
	input  logic [lphm_pkg::KEY_W-1:0]     key_raw,
	output logic [lphm_pkg::KEY_W-1:0]     key_norm,
	output logic [lphm_pkg::SLOT_BITS-1:0] home_idx
);

	always_comb begin
		logic                           alive;
		logic [7:0]                     b;
		logic [lphm_pkg::SLOT_BITS-1:0] h;
		alive    = 1'b1;
		h        = lphm_pkg::HASH_BASIS;
		key_norm = '0;
		for (int i = 0; i < 8; i++) begin
			b = key_raw[8*i +: 8];
			if (i >= lphm_pkg::KEY_BYTES || b == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				key_norm[8*i +: 8] = b;
				h = (h ^ lphm_pkg::SLOT_BITS'(b)) * lphm_pkg::HASH_PRIME;
			end
		end
		home_idx = h;
	end

endmodule

### design/lphm_table.sv
// slot memory, one write and one registered read per cycle
module lphm_table (
	input  logic               clk,
	input  lphm_pkg::tbl_req_t req,
	output lphm_pkg::entry_t   rd_data
);

	lphm_pkg::entry_t mem [lphm_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### tb/lphm_tb_pkg.sv
`timescale 1ns / 1ps
package lphm_tb_pkg;
	import lphm_pkg::*;

	// what one request should produce
	typedef struct {
		status_t          status;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} reply_t;

	// mirror of the slot table plus the queue of replies still owed by the block
	class slot_table_model;
		bit               used[SLOTS];
		logic [KEY_W-1:0] keys[SLOTS];
		logic [VAL_W-1:0] values[SLOTS];
		int unsigned      occupancy;
		reply_t           awaiting[$];
		int               mismatches;
		int               inserts, updates, full_puts, hits, misses;

		// trims the key at its first zero byte and returns its 64-bit fnv-1a hash
		static function logic [63:0] fold_key(input logic [KEY_W-1:0] raw,
				output logic [KEY_W-1:0] norm);
			logic [63:0] h;
			logic [7:0]  b;
			bit          ended;
			h = FNV_BASIS;
			norm = '0;
			ended = 1'b0;
			for (int i = 0; i < KEY_BYTES; i++) begin
				b = raw[8*i +: 8];
				if (b == 8'h00)
					ended = 1'b1;
				if (!ended) begin
					norm[8*i +: 8] = b;
					h = (h ^ {56'd0, b}) * FNV_PRIME;
				end
			end
			return h;
		endfunction

		function int unsigned pending();
			return awaiting.size();
		endfunction

		function void note_request(logic req, logic [KEY_W-1:0] raw, logic [VAL_W-1:0] wval);
			logic [KEY_W-1:0] norm;
			logic [63:0]      h;
			int unsigned      slot;
			reply_t           r;
			h = fold_key(raw, norm);
			slot = h % SLOTS;
			if (req == REQ_PUT)
				r.status = ST_FULL;
			else
				r.status = ST_NOT_FOUND;
			r.value = '0;
			for (int t = 0; t < SLOTS; t++) begin
				if (!used[slot]) begin
					if (req == REQ_PUT) begin
						used[slot] = 1'b1;
						keys[slot] = norm;
						values[slot] = wval;
						occupancy++;
						inserts++;
						r.status = ST_OK;
					end
					break;
				end
				if (keys[slot] == norm) begin
					if (req == REQ_PUT) begin
						values[slot] = wval;
						updates++;
					end else begin
						r.value = values[slot];
						hits++;
					end
					r.status = ST_OK;
					break;
				end
				slot = (slot + 1) % SLOTS;
			end
			if (r.status == ST_FULL)
				full_puts++;
			if (r.status == ST_NOT_FOUND)
				misses++;
			r.count = CNT_W'(occupancy);
			awaiting.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [1:0] st, logic [VAL_W-1:0] val, logic [CNT_W-1:0] cnt);
			reply_t want;
			if (awaiting.size() == 0) begin
				report($sformatf("result with no request waiting (status %0d)", st));
				return;
			end
			want = awaiting.pop_front();
			if (st !== want.status)
				report($sformatf("status %0d, expected %s", st, want.status.name()));
			if (val !== want.value)
				report($sformatf("read_value %h, expected %h", val, want.value));
			if (cnt !== want.count)
				report($sformatf("entry_count %0d, expected %0d", cnt, want.count));
		endtask
	endclass

endpackage

### tb/tb_linear_probe_hash_map_top.sv
`timescale 1ns / 1ps
module tb_linear_probe_hash_map_top;
	import lphm_pkg::*;
	import lphm_tb_pkg::*;

	// cycles with no item moving on either side before the run is abandoned;
	// the slowest legal gap is a long sender pause plus a full probe plus a long stall
	localparam int STALL_LIMIT  = 3000;
	// quiet time at the end, well past a full probe of every slot
	localparam int DRAIN_CYCLES = 3 * SLOTS;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     req_type;
	logic [KEY_W-1:0]         key_bytes;
	logic signed [VAL_W-1:0]  write_value;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               status;
	logic signed [VAL_W-1:0]  read_value;
	logic [CNT_W-1:0]         entry_count;

	slot_table_model  table_model;
	// trimmed keys that have been offered to a put, reused to hit stored entries
	logic [KEY_W-1:0] stored_keys[$];
	// when set, neither side idles
	bit               steady_flow;
	int               quiet_cycles;

	linear_probe_hash_map_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key_bytes  (key_bytes),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// monitor: both handshakes are sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (in_valid && in_ready)
			table_model.note_request(req_type, key_bytes, write_value);
		if (out_valid && out_ready)
			table_model.check_result(status, read_value, entry_count);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("linear_probe_hash_map_top verification failed");
			$finish;
		end
	end

	// mostly short idles, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side: ready most of the time, with stalls of random length
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady_flow || $urandom_range(0, 3) != 0) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				repeat (stall_len() - 1) @(negedge clk);
			end
		end
	end

	// a trimmed key of len non-zero bytes
	function automatic logic [KEY_W-1:0] fresh_key(int len);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < len; i++)
			k[8*i +: 8] = 8'($urandom_range(1, 255));
		return k;
	endfunction

	// same key, with random junk past the terminating zero byte
	function automatic logic [KEY_W-1:0] respell(logic [KEY_W-1:0] norm);
		logic [KEY_W-1:0] k;
		int               len;
		k = norm;
		len = 0;
		while (len < KEY_BYTES && norm[8*len +: 8] != 8'h00)
			len++;
		for (int i = len + 1; i < KEY_BYTES; i++)
			k[8*i +: 8] = 8'($urandom_range(0, 255));
		return k;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// offer one item, hold it until taken, then perhaps idle for a while
	task send_request(logic req, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
		int g;
		@(negedge clk);
		in_valid = 1'b1;
		req_type = req;
		key_bytes = key;
		write_value = val;
		do
			@(posedge clk);
		while (!in_ready);
		g = steady_flow ? 0 : idle_gap();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// stop sending until the block owes nothing
	task settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (table_model.pending() != 0)
			@(posedge clk);
	endtask

	task directed_checks();
		logic [KEY_W-1:0] norm;
		logic [63:0]      h;
		logic [7:0]       wrap_bytes[$];
		// one-byte keys whose home is the last slot, so their probes wrap round
		for (int b = 1; b < 256; b++) begin
			h = slot_table_model::fold_key(KEY_W'(b), norm);
			if (h % SLOTS == SLOTS - 1)
				wrap_bytes.push_back(8'(b));
		end

		// lookup on the freshly cleared table
		send_request(REQ_GET, 64'h0, 32'h1234_5678);
		// empty key, junk after the leading zero byte must be ignored
		send_request(REQ_PUT, 64'hFFFF_FFFF_FFFF_FF00, 32'h7FFF_FFFF);
		send_request(REQ_GET, 64'h0, 32'h0);
		// longest key, all bits set, most negative value
		send_request(REQ_PUT, '1, 32'h8000_0000);
		send_request(REQ_GET, '1, 32'hFFFF_FFFF);
		// two-byte key with junk past its terminator, then an update under other junk
		send_request(REQ_PUT, 64'hDEAD_BEEF_C000_6261, 32'hFFFF_FFFF);
		send_request(REQ_GET, 64'h0000_0000_0000_6261, 32'h0);
		send_request(REQ_PUT, 64'h0102_0304_0500_6261, 32'h0);
		send_request(REQ_GET, 64'h5500_0000_0000_6261, 32'h0);
		// collision at the top slot: second key wraps, third misses after probing
		send_request(REQ_PUT, KEY_W'(wrap_bytes[0]), 32'h0000_00A5);
		send_request(REQ_PUT, KEY_W'(wrap_bytes[1]), 32'h0000_005A);
		send_request(REQ_GET, KEY_W'(wrap_bytes[1]), 32'h0);
		send_request(REQ_GET, KEY_W'(wrap_bytes[0]), 32'h0);
		send_request(REQ_GET, KEY_W'(wrap_bytes[2]), 32'h0);
		// seven-byte key against an eight-byte key sharing its first seven bytes
		send_request(REQ_PUT, 64'h0077_6655_4433_2211, 32'h0000_0001);
		send_request(REQ_GET, 64'hFF77_6655_4433_2211, 32'h0);
		send_request(REQ_GET, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
		send_request(REQ_PUT, '1, 32'h7FFF_FFFF);
		send_request(REQ_GET, 64'h0077_6655_4433_2211, 32'h0);

		stored_keys.push_back(64'h0);
		stored_keys.push_back('1);
		stored_keys.push_back(64'h6261);
		stored_keys.push_back(KEY_W'(wrap_bytes[0]));
		stored_keys.push_back(KEY_W'(wrap_bytes[1]));
		stored_keys.push_back(64'h0077_6655_4433_2211);
	endtask

	// mostly puts and gets on known keys, a trickle of new keys so the table fills
	// part way through the run, and some raw noise
	task random_phase(int n);
		int               r;
		logic             req;
		logic [KEY_W-1:0] norm;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_request(1'($urandom_range(0, 1)), {$urandom, $urandom}, pick_value());
			end else begin
				req = (r < 55) ? REQ_PUT : REQ_GET;
				if (stored_keys.size() == 0 || $urandom_range(0, 15) == 0) begin
					norm = fresh_key($urandom_range(0, KEY_BYTES));
					if (req == REQ_PUT)
						stored_keys.push_back(norm);
				end else begin
					norm = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
				end
				send_request(req, respell(norm), pick_value());
			end
		end
	endtask

	initial begin
		table_model = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PUT;
		key_bytes = '0;
		write_value = '0;
		steady_flow = 1'b0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// in_ready stays low through the clearing pass; send_request simply waits
		directed_checks();
		settle();
		random_phase(120);
		// a stretch with no idling on either side
		steady_flow = 1'b1;
		random_phase(60);
		steady_flow = 1'b0;
		settle();
		random_phase(220);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d inserts, %0d updates, %0d puts refused as full",
			table_model.inserts + table_model.updates + table_model.full_puts
			+ table_model.hits + table_model.misses,
			table_model.inserts, table_model.updates, table_model.full_puts);
		$display("lookups: %0d hits, %0d misses; %0d of %0d slots in use at the end",
			table_model.hits, table_model.misses, table_model.occupancy, SLOTS);
		if (table_model.mismatches == 0)
			$display("linear_probe_hash_map_top verification clean");
		else
			$display("linear_probe_hash_map_top verification failed");
		$finish;
	end

endmodule

### filelist.f
design/lphm_pkg.sv
design/lphm_hash.sv
design/lphm_table.sv
design/linear_probe_hash_map_top.sv
tb/lphm_tb_pkg.sv
tb/tb_linear_probe_hash_map_top.sv
